// File: sv/text_terminal_cursor_scroll_top_macros.svh
// Assertion macros for the text terminal block.
// Used by the checker module; expects clk and rst in the enclosing scope.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TTCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal check failed");

// Next-cycle implication, disabled while reset is high.
`define TTCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal check failed");

// Next-cycle implication that is checked through reset as well.
`define TTCS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("terminal check failed");

`endif

// File: sv/ttcs_pkg.sv
// Shared types and character codes for the text terminal block.
// No dependencies.
package ttcs_pkg;

  localparam logic [7:0] CODE_NUL       = 8'd0;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Access strobes from the control logic to the cell store.
  typedef struct packed {
    logic we;
    logic re;
  } ttcs_mem_ctl_t;

endpackage

// File: sv/ttcs_cell_store.sv
// Character cell memory of the text terminal, with its clearing pass after reset.
// Depends on ttcs_pkg for the access strobe struct.
module ttcs_cell_store #(
  parameter int ROWS    = 36,
  parameter int COLUMNS = 64
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ttcs_pkg::ttcs_mem_ctl_t                    ctl,
  input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]   waddr,
  input  logic [7:0]                                 wdata,
  input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]   raddr,
  output logic [7:0]                                 rdata,
  output logic                                       busy
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = $clog2(ROWS) + CW;
  localparam int DEPTH = ROWS * (1 << CW);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // The sweep owns the write port until every entry holds zero.
  assign wr_en   = busy | ctl.we;
  assign wr_addr = busy ? clr_addr : waddr;
  assign wr_data = busy ? 8'd0 : wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/text_terminal_cursor_scroll_top.sv
// Top level of the text terminal: cursor, ring offset, access sequencer, result register.
// Depends on ttcs_pkg and ttcs_cell_store.
//
//   Channel  Dir  Handshake            Payload
//   s_*      in   s_tvalid / s_tready  tdata: char_code, read_row, read_col; tuser: func
//   m_*      out  m_tvalid / m_tready  tdata: cursor_col, cursor_row, cell_char, scrolled
//
// A put steps the sequencer through accept, execute and finish; a read in range also waits
// for the store between execute and finish, and an out-of-range read skips that wait. Finish
// loads the result once the output register is free, and the next beat is taken in the cycle
// after the result is loaded. A put that scrolls first clears the old top row, cell by cell.
// After reset the store is swept, all ROWS * 2**clog2(COLUMNS) entries, with s_tready low.
// A result waits in the output register; the next beat is accepted and worked meanwhile
// and holds at its end until that register is free.
module text_terminal_cursor_scroll_top #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 36
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [7:0] char_code, [13:8] read_row, [19:14] read_col
  input  logic [0:0]  s_tuser,  // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // [5:0] cursor_col, [11:6] cursor_row, [19:12] cell_char,
                                // [20] scrolled
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = RW + CW;
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_RDWAIT = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] top_row;
  logic [CW-1:0] clr_col;

  logic       it_func;
  logic [7:0] it_code;
  logic [5:0] it_rrow;
  logic [5:0] it_rcol;

  logic [7:0]  res_cell;
  logic        res_scroll;
  logic [23:0] out_data;
  logic        out_load;

  ttcs_pkg::ttcs_mem_ctl_t mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          clr_busy;

  logic          rd_in_range;
  logic [RW-1:0] rd_prow;
  logic [RW-1:0] cur_prow;
  logic [CW-1:0] bs_col;
  logic [RW-1:0] bs_row;

  // Display row to physical row: both operands are below ROWS, so one subtract wraps it.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] row,
                                             input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  assign rd_in_range = ({1'b0, it_rrow} < 7'(ROWS)) && ({3'b000, it_rcol} < 9'(COLUMNS));
  assign rd_prow     = phys_row(RW'(it_rrow), top_row);
  assign cur_prow    = phys_row(cur_row, top_row);

  // Backspace target; at the origin the cursor stays put.
  always_comb begin
    bs_col = cur_col;
    bs_row = cur_row;
    if (cur_col != '0) begin
      bs_col = cur_col - 1'b1;
    end else if (cur_row != '0) begin
      bs_col = COL_LAST;
      bs_row = cur_row - 1'b1;
    end
  end

  // One item is in flight at a time, so a read never meets a write to the same cell.
  always_comb begin
    mem_ctl   = '0;
    mem_waddr = {top_row, clr_col};
    mem_wdata = 8'd0;
    mem_raddr = {rd_prow, CW'(it_rcol)};
    unique case (state)
      ST_EXEC: begin
        if (it_func == ttcs_pkg::FUNC_READ) begin
          mem_ctl.re = rd_in_range;
        end else if (it_code == ttcs_pkg::CODE_BACKSPACE) begin
          mem_ctl.we = 1'b1;
          mem_waddr  = {phys_row(bs_row, top_row), bs_col};
        end else if (it_code != ttcs_pkg::CODE_NEWLINE && it_code != ttcs_pkg::CODE_NUL) begin
          mem_ctl.we = 1'b1;
          mem_waddr  = {cur_prow, cur_col};
          mem_wdata  = it_code;
        end
      end
      ST_SCROLL: begin
        mem_ctl.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  ttcs_cell_store #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (clr_busy)
  );

  assign s_tready = (state == ST_IDLE) && !clr_busy;
  assign m_tdata  = out_data;
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cur_col  <= '0;
      cur_row  <= '0;
      top_row  <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            it_func <= s_tuser[0];
            it_code <= s_tdata[7:0];
            it_rrow <= s_tdata[13:8];
            it_rcol <= s_tdata[19:14];
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_cell   <= 8'd0;
          res_scroll <= 1'b0;
          state      <= ST_FINISH;
          if (it_func == ttcs_pkg::FUNC_READ) begin
            if (rd_in_range) begin
              state <= ST_RDWAIT;
            end
          end else if (it_code == ttcs_pkg::CODE_NEWLINE) begin
            cur_col <= '0;
            if (cur_row != ROW_LAST) begin
              cur_row <= cur_row + 1'b1;
            end else begin
              res_scroll <= 1'b1;
              clr_col    <= '0;
              state      <= ST_SCROLL;
            end
          end else if (it_code == ttcs_pkg::CODE_BACKSPACE) begin
            cur_col <= bs_col;
            cur_row <= bs_row;
          end else if (it_code != ttcs_pkg::CODE_NUL) begin
            if (cur_col != COL_LAST) begin
              cur_col <= cur_col + 1'b1;
            end else begin
              cur_col <= '0;
              if (cur_row != ROW_LAST) begin
                cur_row <= cur_row + 1'b1;
              end else begin
                res_scroll <= 1'b1;
                clr_col    <= '0;
                state      <= ST_SCROLL;
              end
            end
          end
        end
        ST_RDWAIT: begin
          res_cell <= mem_rdata;
          state    <= ST_FINISH;
        end
        ST_SCROLL: begin
          // The old top physical row is cleared and becomes the bottom display row.
          clr_col <= clr_col + 1'b1;
          if (clr_col == COL_LAST) begin
            top_row <= (top_row == ROW_LAST) ? '0 : top_row + 1'b1;
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            out_data <= {3'b000, res_scroll, res_cell, 6'(cur_row), 6'(cur_col)};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/ttcs_checker.sv
// Port-level checks for the text terminal, bound to the top level.
// Depends on text_terminal_cursor_scroll_top_macros.svh.
`include "text_terminal_cursor_scroll_top_macros.svh"

module ttcs_checker #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 36
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  `TTCS_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !m_tvalid)
  `TTCS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `TTCS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  `TTCS_ASSERT_NOW(a_scroll_pos, m_tvalid && m_tdata[20],
                   (m_tdata[11:6] == 6'(ROWS - 1)) && (m_tdata[5:0] == 6'd0))
  `TTCS_ASSERT_NOW(a_cursor_range, m_tvalid,
                   ({1'b0, m_tdata[11:6]} < 7'(ROWS)) &&
                   ({3'b000, m_tdata[5:0]} < 9'(COLUMNS)))

endmodule

bind text_terminal_cursor_scroll_top ttcs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_ttcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
